[design/fctf_pkg.sv]
// shared constants, codes and control structs of the framed command transmit ring
`timescale 1ns / 1ps
package fctf_pkg;

	localparam int RING_SIZE_DEF = 64;
	localparam int BYTE_W        = 8;
	localparam int QCNT_W        = 3;

	localparam logic [BYTE_W-1:0] ADDR_RESET    = 8'd128;
	localparam logic [BYTE_W-1:0] CHECKSUM_MASK = 8'h7F;

	// request kinds
	localparam logic KIND_SEND  = 1'b0;
	localparam logic KIND_READY = 1'b1;

	// position of a byte inside a frame
	localparam logic [1:0] FB_ADDR = 2'd0;
	localparam logic [1:0] FB_CMD  = 2'd1;
	localparam logic [1:0] FB_DATA = 2'd2;
	localparam logic [1:0] FB_SUM  = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic push;
		logic pop;
		logic sleep;
		logic overflow;
		logic store_result;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic last_byte;
		logic out_free;
	} dp_stat_t;

endpackage

[design/fctf_if.sv]
// request and result channel interfaces of the framed command transmit ring
`timescale 1ns / 1ps
interface fctf_req_if;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic [fctf_pkg::BYTE_W-1:0] command;
	logic [fctf_pkg::BYTE_W-1:0] data;

	modport source (output valid, output kind, output command, output data, input ready);
	modport sink   (input valid, input kind, input command, input data, output ready);
endinterface

interface fctf_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        status;
	logic [fctf_pkg::QCNT_W-1:0] bytes_queued;
	logic                        tx_valid;
	logic [fctf_pkg::BYTE_W-1:0] tx_byte;
	logic                        sender_active;

	modport source (output valid, output status, output bytes_queued, output tx_valid,
		output tx_byte, output sender_active, input ready);
	modport sink   (input valid, input status, input bytes_queued, input tx_valid,
		input tx_byte, input sender_active, output ready);
endinterface

[design/fctf_ctrl.sv]
// sequencing controller: accepts a request, steps pushes or one pop, hands off the result
`timescale 1ns / 1ps
module fctf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_kind,
	output logic                in_ready,
	input  fctf_pkg::dp_stat_t  stat,
	output fctf_pkg::dp_cmd_t   cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PUSH = 4'b0010,
		ST_POP  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and datapath commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					if (in_kind == fctf_pkg::KIND_SEND) begin
						state_d = ST_PUSH;
					end else if (stat.empty) begin
						cmd.sleep = 1'b1;
						state_d   = ST_DONE;
					end else begin
						state_d = ST_POP;
					end
				end
			end
			ST_PUSH: begin
				if (stat.full) begin
					cmd.overflow = 1'b1;
					state_d      = ST_DONE;
				end else begin
					cmd.push = 1'b1;
					if (stat.last_byte) begin
						state_d = ST_DONE;
					end
				end
			end
			ST_POP: begin
				cmd.pop = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.store_result = 1'b1;
					state_d          = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[design/fctf_dp.sv]
// datapath: ring memory, pointers, sender flag, frame builder and result register
`timescale 1ns / 1ps
module fctf_dp #(
	parameter int RING_SIZE = fctf_pkg::RING_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [fctf_pkg::BYTE_W-1:0]  cfg_wr_data,
	input  logic [fctf_pkg::BYTE_W-1:0]  in_command,
	input  logic [fctf_pkg::BYTE_W-1:0]  in_data,
	input  fctf_pkg::dp_cmd_t            cmd,
	output fctf_pkg::dp_stat_t           stat,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         out_status,
	output logic [fctf_pkg::QCNT_W-1:0]  out_bytes_queued,
	output logic                         out_tx_valid,
	output logic [fctf_pkg::BYTE_W-1:0]  out_tx_byte,
	output logic                         out_sender_active
);

	localparam int PTR_W = $clog2(RING_SIZE);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_SIZE - 1);
	localparam logic [fctf_pkg::QCNT_W-1:0] LAST_IDX = fctf_pkg::QCNT_W'(3);

	logic [fctf_pkg::BYTE_W-1:0] mem [RING_SIZE];

	logic [fctf_pkg::BYTE_W-1:0] dev_addr_q;
	logic [fctf_pkg::BYTE_W-1:0] command_q;
	logic [fctf_pkg::BYTE_W-1:0] data_q;
	logic [fctf_pkg::BYTE_W-1:0] rd_data_q;
	logic [PTR_W-1:0]            wptr_q;
	logic [PTR_W-1:0]            rptr_q;
	logic [PTR_W-1:0]            wptr_next;
	logic [PTR_W-1:0]            rptr_next;
	logic                        flag_q;
	logic                        status_q;
	logic [fctf_pkg::QCNT_W-1:0] queued_q;
	logic                        popped_q;
	logic [fctf_pkg::BYTE_W-1:0] checksum;
	logic [fctf_pkg::BYTE_W-1:0] push_byte;

	logic                        out_valid_q;
	logic                        out_status_q;
	logic [fctf_pkg::QCNT_W-1:0] out_queued_q;
	logic                        out_tx_valid_q;
	logic [fctf_pkg::BYTE_W-1:0] out_tx_byte_q;
	logic                        out_active_q;

	// pointer advance with wrap for any ring size
	assign wptr_next = (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
	assign rptr_next = (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;

	// frame byte selection
	assign checksum = (dev_addr_q + command_q + data_q) & fctf_pkg::CHECKSUM_MASK;

	always_comb begin
		unique case (queued_q[1:0])
			fctf_pkg::FB_ADDR: push_byte = dev_addr_q;
			fctf_pkg::FB_CMD:  push_byte = command_q;
			fctf_pkg::FB_DATA: push_byte = data_q;
			fctf_pkg::FB_SUM:  push_byte = checksum;
			default:           push_byte = checksum;
		endcase
	end

	// status toward the controller
	assign stat.full      = (wptr_next == rptr_q);
	assign stat.empty     = (wptr_q == rptr_q);
	assign stat.last_byte = (queued_q == LAST_IDX);
	assign stat.out_free  = !out_valid_q || out_ready;

	// ring memory, single write and registered read
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wptr_next] <= push_byte;
		end
		if (cmd.pop) begin
			rd_data_q <= mem[rptr_next];
		end
	end

	// captured request payload
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			command_q <= in_command;
			data_q    <= in_data;
		end
	end

	// configuration, pointers, flag and per-request counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= fctf_pkg::ADDR_RESET;
			wptr_q     <= '0;
			rptr_q     <= '0;
			flag_q     <= 1'b0;
			status_q   <= 1'b0;
			queued_q   <= '0;
			popped_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				dev_addr_q <= cfg_wr_data;
			end
			if (cmd.load_item) begin
				status_q <= 1'b0;
				queued_q <= '0;
				popped_q <= 1'b0;
			end
			if (cmd.push) begin
				wptr_q   <= wptr_next;
				flag_q   <= 1'b1;
				queued_q <= queued_q + 1'b1;
			end
			if (cmd.overflow) begin
				status_q <= 1'b1;
			end
			if (cmd.pop) begin
				rptr_q   <= rptr_next;
				popped_q <= 1'b1;
			end
			if (cmd.sleep) begin
				flag_q <= 1'b0;
			end
		end
	end

	// result valid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.store_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.store_result) begin
			out_status_q   <= status_q;
			out_queued_q   <= queued_q;
			out_tx_valid_q <= popped_q;
			out_tx_byte_q  <= popped_q ? rd_data_q : '0;
			out_active_q   <= flag_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign out_status        = out_status_q;
	assign out_bytes_queued  = out_queued_q;
	assign out_tx_valid      = out_tx_valid_q;
	assign out_tx_byte       = out_tx_byte_q;
	assign out_sender_active = out_active_q;

`ifndef SYNTHESIS
	// a byte is never written over an unread one
	assert property (@(posedge clk) disable iff (!arst_n) cmd.push |-> !stat.full)
		else $error("push into a full ring");

	// the sender flag is up whenever bytes wait in the ring
	assert property (@(posedge clk) disable iff (!arst_n) !stat.empty |-> flag_q)
		else $error("ring holds bytes while sender is inactive");

	// a pop is only issued with data present
	assert property (@(posedge clk) disable iff (!arst_n) cmd.pop |-> !stat.empty)
		else $error("pop from an empty ring");

	// a result never reports both a popped byte and send fields
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_tx_valid_q |-> !out_status_q && (out_queued_q == '0))
		else $error("mixed send and pop result");
`endif

endmodule

[design/framed_command_tx_fifo_unit.sv]
// top level of the framed command transmit ring
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    kind, command, data
//   rsp      out  valid/ready    status, bytes_queued, tx_valid, tx_byte, sender_active
//   cfg      in   cfg_wr_en      cfg_wr_data (device address)
//
// a send request runs accept, four memory writes and result load before the next accept
// (when the ring fills, it stops writing and goes on to its result load);
// a transmitter-ready request runs accept, memory read and result load, and skips the read on an empty ring
// one request is in work at a time; a finished result sits in the output register
// and the next request is accepted while it waits, then holds in its result cycle until taken
// reset clears the pointers, the sender flag and the address register to 128;
// the ring memory is not cleared, entries are read only after being written
`timescale 1ns / 1ps
module framed_command_tx_fifo_unit #(
	parameter int RING_SIZE = fctf_pkg::RING_SIZE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	fctf_req_if.sink                    req,
	fctf_rsp_if.source                  rsp,
	input  logic                        cfg_wr_en,
	input  logic [fctf_pkg::BYTE_W-1:0] cfg_wr_data
);

	fctf_pkg::dp_cmd_t  cmd;
	fctf_pkg::dp_stat_t stat;

	// controller
	fctf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_kind  (req.kind),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	fctf_dp #(
		.RING_SIZE (RING_SIZE)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.in_command        (req.command),
		.in_data           (req.data),
		.cmd               (cmd),
		.stat              (stat),
		.out_valid         (rsp.valid),
		.out_ready         (rsp.ready),
		.out_status        (rsp.status),
		.out_bytes_queued  (rsp.bytes_queued),
		.out_tx_valid      (rsp.tx_valid),
		.out_tx_byte       (rsp.tx_byte),
		.out_sender_active (rsp.sender_active)
	);

endmodule

[test/framed_command_tx_fifo_unit_tb.sv]
// testbench for the framed command transmit ring: directed frames, overflow and random traffic
`timescale 1ns / 1ps
module framed_command_tx_fifo_unit_tb;

	localparam int PTR_W      = $clog2(fctf_pkg::RING_SIZE_DEF);
	localparam int CYCLE_CAP  = 400000;
	localparam int MAX_REPORT = 10;

	typedef logic [fctf_pkg::BYTE_W-1:0] byte_t;

	typedef struct packed {
		logic                        status;
		logic [fctf_pkg::QCNT_W-1:0] bytes_queued;
		logic                        tx_valid;
		byte_t                       tx_byte;
		logic                        sender_active;
	} tx_result_t;

	logic  clk;
	logic  arst_n;
	logic  cfg_wr_en;
	byte_t cfg_wr_data;

	fctf_req_if req ();
	fctf_rsp_if rsp ();

	framed_command_tx_fifo_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// shadow copy of the ring, its pointers and the address register
	byte_t             shadow_ring [fctf_pkg::RING_SIZE_DEF];
	logic [PTR_W-1:0]  shadow_wr_ptr;
	logic [PTR_W-1:0]  shadow_rd_ptr;
	logic              shadow_active;
	byte_t             shadow_dev_addr;
	logic              last_send_overflowed;

	tx_result_t ring_results_due [$];
	int         mismatch_count;
	int         cycle_count;
	bit         src_gaps;
	bit         sink_stalls;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run-time limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_CAP) begin
			$display("framed_command_tx_fifo_unit_tb failed");
			$finish;
		end
	end

	// frame a send request or pop a byte, returning the result the ring must give
	function automatic tx_result_t ring_apply(input logic k, input byte_t c, input byte_t d);
		tx_result_t       r;
		byte_t            frame [4];
		logic [PTR_W-1:0] nxt;
		r = '0;
		if (k == fctf_pkg::KIND_SEND) begin
			frame[fctf_pkg::FB_ADDR] = shadow_dev_addr;
			frame[fctf_pkg::FB_CMD]  = c;
			frame[fctf_pkg::FB_DATA] = d;
			frame[fctf_pkg::FB_SUM]  = (shadow_dev_addr + c + d) & fctf_pkg::CHECKSUM_MASK;
			last_send_overflowed = 1'b0;
			for (int i = 0; i < 4; i++) begin
				nxt = shadow_wr_ptr + 1'b1;
				if (nxt == shadow_rd_ptr) begin
					r.status = 1'b1;
					last_send_overflowed = 1'b1;
					break;
				end
				shadow_ring[nxt] = frame[i];
				shadow_wr_ptr    = nxt;
				shadow_active    = 1'b1;
				r.bytes_queued   = r.bytes_queued + 1'b1;
			end
		end else begin
			if (shadow_wr_ptr != shadow_rd_ptr) begin
				shadow_rd_ptr = shadow_rd_ptr + 1'b1;
				r.tx_byte     = shadow_ring[shadow_rd_ptr];
				r.tx_valid    = 1'b1;
			end else begin
				shadow_active = 1'b0;
			end
		end
		r.sender_active = shadow_active;
		return r;
	endfunction

	// sender gap: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!src_gaps || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// drive one request and wait for it to be taken
	task automatic send_request(input logic k, input byte_t c, input byte_t d);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid   <= 1'b1;
		req.kind    <= k;
		req.command <= c;
		req.data    <= d;
		do @(posedge clk); while (req.ready !== 1'b1);
		ring_results_due.push_back(ring_apply(k, c, d));
	endtask

	task automatic send_random_frame();
		send_request(fctf_pkg::KIND_SEND, byte_t'($urandom_range(0, 255)),
			byte_t'($urandom_range(0, 255)));
	endtask

	// ready requests carry random don't-care frame fields
	task automatic send_tx_ready();
		send_request(fctf_pkg::KIND_READY, byte_t'($urandom_range(0, 255)),
			byte_t'($urandom_range(0, 255)));
	endtask

	// drop valid, wait until every result is back, then let the ring sit idle
	task automatic wait_idle();
		req.valid <= 1'b0;
		while (ring_results_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_device_address(input byte_t a);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= a;
		@(posedge clk);
		cfg_wr_en       <= 1'b0;
		shadow_dev_addr  = a;
		@(posedge clk);
	endtask

	// ready on an empty ring right after reset
	task automatic test_empty_pop();
		send_tx_ready();
		send_tx_ready();
	endtask

	// field extremes with the reset address
	task automatic test_frame_fields();
		send_request(fctf_pkg::KIND_SEND, 8'h00, 8'h00);
		send_request(fctf_pkg::KIND_SEND, 8'hFF, 8'hFF);
		repeat (9) send_tx_ready();
	endtask

	// address register at both extremes
	task automatic test_address_extremes();
		set_device_address(8'h00);
		send_request(fctf_pkg::KIND_SEND, 8'h00, 8'h00);
		set_device_address(8'hFF);
		send_request(fctf_pkg::KIND_SEND, 8'hFF, 8'hFF);
		repeat (9) send_tx_ready();
	endtask

	// fill until a frame is cut short, push into the full ring, then drain past empty
	task automatic test_overflow();
		set_device_address(byte_t'($urandom_range(0, 255)));
		last_send_overflowed = 1'b0;
		while (!last_send_overflowed) send_random_frame();
		repeat (3) send_random_frame();
		while (shadow_wr_ptr != shadow_rd_ptr) send_tx_ready();
		repeat (2) send_tx_ready();
	endtask

	// random mix of sends and ready requests
	task automatic test_random_traffic(input int count, input int send_pct,
			input byte_t addr, input bit gaps, input bit stalls);
		set_device_address(addr);
		src_gaps    = gaps;
		sink_stalls = stalls;
		repeat (count) begin
			if ($urandom_range(0, 99) < send_pct)
				send_random_frame();
			else
				send_tx_ready();
		end
	endtask

	// result receiver with random stalls
	initial begin
		int stall_left;
		int r;
		stall_left = 0;
		rsp.ready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!sink_stalls) begin
				rsp.ready <= 1'b1;
			end else if (stall_left > 0) begin
				rsp.ready  <= 1'b0;
				stall_left  = stall_left - 1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					rsp.ready <= 1'b1;
				end else begin
					rsp.ready  <= 1'b0;
					stall_left  = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
				end
			end
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		tx_result_t got;
		tx_result_t want;
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			got = '{rsp.status, rsp.bytes_queued, rsp.tx_valid, rsp.tx_byte, rsp.sender_active};
			if (ring_results_due.size() == 0) begin
				if (mismatch_count < MAX_REPORT)
					$display("unexpected result: st=%0d qd=%0d tv=%0d tb=%02h sa=%0d",
						got.status, got.bytes_queued, got.tx_valid, got.tx_byte,
						got.sender_active);
				mismatch_count++;
			end else begin
				want = ring_results_due.pop_front();
				if (got !== want) begin
					if (mismatch_count < MAX_REPORT) begin
						$display("mismatch: expected st=%0d qd=%0d tv=%0d tb=%02h sa=%0d",
							want.status, want.bytes_queued, want.tx_valid, want.tx_byte,
							want.sender_active);
						$display("          actual   st=%0d qd=%0d tv=%0d tb=%02h sa=%0d",
							got.status, got.bytes_queued, got.tx_valid, got.tx_byte,
							got.sender_active);
					end
					mismatch_count++;
				end
			end
		end
	end

	// test sequence
	initial begin
		arst_n               = 1'b0;
		cfg_wr_en            = 1'b0;
		cfg_wr_data          = '0;
		req.valid            = 1'b0;
		req.kind             = fctf_pkg::KIND_SEND;
		req.command          = '0;
		req.data             = '0;
		shadow_wr_ptr        = '0;
		shadow_rd_ptr        = '0;
		shadow_active        = 1'b0;
		shadow_dev_addr      = fctf_pkg::ADDR_RESET;
		last_send_overflowed = 1'b0;
		mismatch_count       = 0;
		cycle_count          = 0;
		src_gaps             = 1'b1;
		sink_stalls          = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_pop();
		test_frame_fields();
		test_address_extremes();
		test_overflow();
		test_random_traffic(90, 75, 8'h80, 1'b1, 1'b1);
		test_random_traffic(90, 30, byte_t'($urandom_range(0, 255)), 1'b1, 1'b1);
		test_random_traffic(90, 60, 8'hFF, 1'b0, 1'b0);
		test_random_traffic(90, 50, 8'h00, 1'b1, 1'b1);

		wait_idle();
		if (mismatch_count == 0 && ring_results_due.size() == 0)
			$display("framed_command_tx_fifo_unit_tb passed");
		else
			$display("framed_command_tx_fifo_unit_tb failed");
		$finish;
	end

endmodule
